// ===== rtl/csem_pkg.sv =====
`default_nettype none
package csem_pkg;

    localparam int NUM_SEMS_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 10;

    localparam int OP_W     = 3;
    localparam int SEMID_W  = 6;
    localparam int COUNT_W  = 32;
    localparam int CPID_W   = 10;
    localparam int STATUS_W = 3;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 56;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_WAIT    = 3'd1,
        OP_POST    = 3'd2,
        OP_DESTROY = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_INVALID = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_Q_FULL  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ALU_PASS    = 2'd0,
        ALU_DEC     = 2'd1,
        ALU_INC_SAT = 2'd2
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_SCAN = 3'd1,
        S_READ = 3'd2,
        S_EXEC = 3'd3,
        S_PID  = 3'd4,
        S_PIDD = 3'd5,
        S_RESP = 3'd6
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/csem_ram.sv =====
`default_nettype none
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/csem_alu.sv =====
`default_nettype none
module csem_alu (
    input  wire csem_pkg::alu_op_t             op,
    input  wire logic [csem_pkg::COUNT_W-1:0]  a,
    output logic      [csem_pkg::COUNT_W-1:0]  y,
    output logic                               zero
);

    always_comb
    begin
        zero = (a == '0);
        case (op)
            csem_pkg::ALU_DEC:     y = a - 32'd1;
            csem_pkg::ALU_INC_SAT: y = (a == '1) ? a : a + 32'd1;
            default:               y = a;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/counting_semaphore_table.sv =====
`default_nettype none
// Counting semaphore table.
// Input stream s_axis_*: one word per operation (create, wait, post, destroy,
// read count). Output stream m_axis_*: result words; tlast marks the final
// result of an operation. Destroy gives one word per queued process id in
// FIFO order (one word if the queue is empty), every other operation gives exactly one word.
// Sequence: wait, post and read go through the read, execute and result
// states; post with a waiter and destroy with a non-empty queue add a pid read
// and a pid capture state before each result word. A bad handle or op goes
// straight to the result state. Create scans the in-use flags one entry a
// cycle from entry 0 and stops at the lowest free entry or at the last one.
// Reads of the per-entry metadata memory and the process id memory are
// registered, and each memory has a single read port.
// s_axis_tready is high only while the sequencer is idle, which it re-enters
// as the last result word is loaded into the output register.
// A finished word waits in the output register while the next operation is
// accepted; a stalled receiver holds the sequencer in its result state until
// the register drains.
// Reset frees every entry at once (in-use flags in flip-flops); the memory
// contents need no clearing since create rewrites an entry's metadata.
module counting_semaphore_table #(
    parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = csem_pkg::PID_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // op[2:0], sem_id[8:3], init_value[40:9], caller_pid[50:41], zero pad
    input  wire logic [csem_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // status[2:0], handle[8:3], count_value[40:9], woken_pid[50:41],
    // woken_valid[51], zero pad
    output logic      [csem_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int Q_W    = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int META_W = csem_pkg::COUNT_W + 2 * Q_W + OCC_W;
    localparam int PA_W   = SEM_W + Q_W;

    csem_pkg::state_t state_reg, state_next;

    logic [csem_pkg::OP_W-1:0]     op_reg;
    logic [SEM_W-1:0]              sem_reg, sem_next;
    logic [csem_pkg::COUNT_W-1:0]  init_reg;
    logic [PID_BITS-1:0]           pid_reg;
    logic [SEM_W-1:0]              scan_reg, scan_next;
    logic [Q_W-1:0]                ptr_reg, ptr_next;
    logic [OCC_W-1:0]              rem_reg, rem_next;
    logic                          clr_reg, clr_next;
    logic [NUM_SEMS-1:0]           in_use_reg, in_use_next;

    logic [csem_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [csem_pkg::SEMID_W-1:0]  res_handle_reg, res_handle_next;
    logic [csem_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [csem_pkg::CPID_W-1:0]   res_pid_reg, res_pid_next;
    logic                          res_wv_reg, res_wv_next;
    logic                          res_last_reg, res_last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [csem_pkg::OUT_W-1:0]    out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    logic                          accept, out_free;
    logic [csem_pkg::OP_W-1:0]     in_op;
    logic [15:0]                   in_sem16, in_pid16, rd_pid16;
    logic [SEM_W-1:0]              in_sem_idx;
    logic                          in_sem_ok;

    logic                          meta_we;
    logic [SEM_W-1:0]              meta_waddr;
    logic [META_W-1:0]             meta_wdata, meta_rdata;
    logic [csem_pkg::COUNT_W-1:0]  m_count;
    logic [Q_W-1:0]                m_head, m_tail;
    logic [OCC_W-1:0]              m_occ;

    logic                          pid_we;
    logic [PA_W-1:0]               pid_waddr, pid_raddr;
    logic [PID_BITS-1:0]           pid_rdata;

    csem_pkg::alu_op_t             alu_op;
    logic [csem_pkg::COUNT_W-1:0]  alu_y;
    logic                          alu_zero;

    function automatic logic [Q_W-1:0] ptr_adv(input logic [Q_W-1:0] p);
        ptr_adv = (p == Q_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign in_op      = s_axis_tdata[2:0];
    assign in_sem16   = {10'd0, s_axis_tdata[8:3]};
    assign in_sem_idx = SEM_W'(in_sem16);
    assign in_sem_ok  = (in_sem16 < 16'(NUM_SEMS)) && in_use_reg[in_sem_idx];
    assign in_pid16   = {6'd0, s_axis_tdata[50:41]};
    assign rd_pid16   = 16'(pid_rdata);

    assign m_count = meta_rdata[csem_pkg::COUNT_W-1:0];
    assign m_head  = meta_rdata[csem_pkg::COUNT_W +: Q_W];
    assign m_tail  = meta_rdata[csem_pkg::COUNT_W + Q_W +: Q_W];
    assign m_occ   = meta_rdata[csem_pkg::COUNT_W + 2 * Q_W +: OCC_W];

    assign s_axis_tready = (state_reg == csem_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    csem_ram #(.WIDTH(META_W), .DEPTH(NUM_SEMS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (sem_reg),
        .rdata (meta_rdata)
    );

    csem_ram #(.WIDTH(PID_BITS), .DEPTH(NUM_SEMS << Q_W)) u_pids (
        .clk   (clk),
        .we    (pid_we),
        .waddr (pid_waddr),
        .wdata (pid_reg),
        .raddr (pid_raddr),
        .rdata (pid_rdata)
    );

    csem_alu u_alu (
        .op   (alu_op),
        .a    (m_count),
        .y    (alu_y),
        .zero (alu_zero)
    );

    assign pid_raddr = {sem_reg, ptr_reg};
    assign pid_waddr = {sem_reg, m_tail};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csem_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == csem_pkg::OP_CREATE)
                        state_next = csem_pkg::S_SCAN;
                    else if (in_op > csem_pkg::OP_READ || !in_sem_ok)
                        state_next = csem_pkg::S_RESP;
                    else
                        state_next = csem_pkg::S_READ;
                end
            end
            csem_pkg::S_SCAN:
            begin
                if (!in_use_reg[scan_reg] || scan_reg == SEM_W'(NUM_SEMS - 1))
                    state_next = csem_pkg::S_RESP;
            end
            csem_pkg::S_READ: state_next = csem_pkg::S_EXEC;
            csem_pkg::S_EXEC:
            begin
                if ((op_reg == csem_pkg::OP_POST || op_reg == csem_pkg::OP_DESTROY)
                    && m_occ != '0)
                    state_next = csem_pkg::S_PID;
                else
                    state_next = csem_pkg::S_RESP;
            end
            csem_pkg::S_PID:  state_next = csem_pkg::S_PIDD;
            csem_pkg::S_PIDD: state_next = csem_pkg::S_RESP;
            csem_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    if (op_reg == csem_pkg::OP_DESTROY && rem_reg > OCC_W'(1))
                        state_next = csem_pkg::S_PID;
                    else
                        state_next = csem_pkg::S_IDLE;
                end
            end
            default: state_next = csem_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        sem_next        = sem_reg;
        scan_next       = scan_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        clr_next        = clr_reg;
        in_use_next     = in_use_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_count_next  = res_count_reg;
        res_pid_next    = res_pid_reg;
        res_wv_next     = res_wv_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        meta_we         = 1'b0;
        meta_waddr      = sem_reg;
        meta_wdata      = meta_rdata;
        pid_we          = 1'b0;
        alu_op          = csem_pkg::ALU_PASS;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            csem_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    sem_next        = in_sem_idx;
                    scan_next       = '0;
                    rem_next        = '0;
                    clr_next        = 1'b0;
                    res_status_next = csem_pkg::ST_INVALID;
                    res_handle_next = '0;
                    res_count_next  = '0;
                    res_pid_next    = '0;
                    res_wv_next     = 1'b0;
                    res_last_next   = 1'b1;
                end
            end
            csem_pkg::S_SCAN:
            begin
                if (!in_use_reg[scan_reg])
                begin
                    meta_we                = 1'b1;
                    meta_waddr             = scan_reg;
                    meta_wdata             = '0;
                    meta_wdata[csem_pkg::COUNT_W-1:0] = init_reg;
                    in_use_next[scan_reg]  = 1'b1;
                    res_status_next        = csem_pkg::ST_DONE;
                    res_handle_next        = csem_pkg::SEMID_W'(16'(scan_reg));
                end
                else if (scan_reg == SEM_W'(NUM_SEMS - 1))
                begin
                    res_status_next = csem_pkg::ST_NO_FREE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            csem_pkg::S_EXEC:
            begin
                res_status_next = csem_pkg::ST_DONE;
                case (op_reg)
                    csem_pkg::OP_WAIT:
                    begin
                        if (!alu_zero)
                        begin
                            alu_op     = csem_pkg::ALU_DEC;
                            meta_we    = 1'b1;
                            meta_wdata[csem_pkg::COUNT_W-1:0] = alu_y;
                        end
                        else if (m_occ == OCC_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = csem_pkg::ST_Q_FULL;
                        end
                        else
                        begin
                            pid_we     = 1'b1;
                            meta_we    = 1'b1;
                            meta_wdata[csem_pkg::COUNT_W + Q_W +: Q_W] = ptr_adv(m_tail);
                            meta_wdata[csem_pkg::COUNT_W + 2 * Q_W +: OCC_W] =
                                m_occ + 1'b1;
                            res_status_next = csem_pkg::ST_BLOCKED;
                        end
                    end
                    csem_pkg::OP_POST:
                    begin
                        alu_op     = csem_pkg::ALU_INC_SAT;
                        meta_we    = 1'b1;
                        meta_wdata[csem_pkg::COUNT_W-1:0] = alu_y;
                        ptr_next   = m_head;
                        rem_next   = OCC_W'(1);
                        if (m_occ != '0)
                        begin
                            meta_wdata[csem_pkg::COUNT_W +: Q_W] = ptr_adv(m_head);
                            meta_wdata[csem_pkg::COUNT_W + 2 * Q_W +: OCC_W] =
                                m_occ - 1'b1;
                        end
                    end
                    csem_pkg::OP_DESTROY:
                    begin
                        ptr_next = m_head;
                        rem_next = m_occ;
                        clr_next = 1'b1;
                    end
                    default:
                    begin
                        res_count_next = m_count;
                    end
                endcase
            end
            csem_pkg::S_PIDD:
            begin
                res_status_next = csem_pkg::ST_DONE;
                res_pid_next    = rd_pid16[csem_pkg::CPID_W-1:0];
                res_wv_next     = 1'b1;
                res_last_next   = (rem_reg == OCC_W'(1));
            end
            csem_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = res_last_reg;
                    out_data_next  = {4'd0, res_wv_reg, res_pid_reg, res_count_reg,
                                      res_handle_reg, res_status_reg};
                    if (op_reg == csem_pkg::OP_DESTROY && rem_reg > OCC_W'(1))
                    begin
                        ptr_next = ptr_adv(ptr_reg);
                        rem_next = rem_reg - 1'b1;
                    end
                    else if (clr_reg)
                    begin
                        in_use_next[sem_reg] = 1'b0;
                        clr_next             = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csem_pkg::S_IDLE;
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
            clr_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            init_reg <= s_axis_tdata[40:9];
            pid_reg  <= PID_BITS'(in_pid16);
        end
        sem_reg        <= sem_next;
        scan_reg       <= scan_next;
        ptr_reg        <= ptr_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_count_reg  <= res_count_next;
        res_pid_reg    <= res_pid_next;
        res_wv_reg     <= res_wv_next;
        res_last_reg   <= res_last_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    a_create_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_op == csem_pkg::OP_CREATE |=> state_reg == csem_pkg::S_SCAN)
        else $error("create did not start the free-entry scan");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == csem_pkg::S_EXEC && in_use_reg[sem_reg]
        |-> m_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == csem_pkg::S_PIDD |-> rem_reg != '0)
        else $error("queue read with nothing queued");

endmodule
`default_nettype wire
